### hdl/oms_pkg.sv
`timescale 1ns / 1ps
package oms_pkg;

  localparam int DEF_HISTORY_DEPTH = 128;
  localparam int DEF_POSITION_BITS = 48;

  localparam int FRAME_W    = 16;
  localparam int SPB_W      = 24;
  localparam int HALF_W     = SPB_W - 1;
  localparam int INTERVAL_W = 24;
  localparam int METER_W    = 3;
  localparam int SWING_W    = 16;
  localparam int DIV_W      = 64;
  localparam int SCALE_W    = 23;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 24'd4410;
  localparam logic [SCALE_W-1:0]    SWING_SCALE    = 23'd6553500;
  localparam logic [METER_W-1:0]    METER_THREE    = 3'd3;
  localparam logic [METER_W-1:0]    METER_FOUR     = 3'd4;
  localparam logic [SWING_W-1:0]    SWING_MAX      = 16'hFFFF;

  localparam int MIN_METER_ONSETS = 8;
  localparam int MIN_INTERVALS    = 4;
  localparam int MIN_SWING_ONSETS = 4;
  localparam int MIN_METER_HITS   = 2;

  typedef struct packed {
    logic accept;
    logic check;
    logic iv_start;
    logic med_rd;
    logic med_cap;
    logic med_start;
    logic med_take;
    logic med_next;
    logic cnt_start;
    logic meter_set;
    logic sw_init;
    logic sw_mod_go;
    logic sw_acc;
    logic sw_zero;
    logic sw_prod;
    logic sw_den;
    logic sw_q_go;
    logic sw_sat;
    logic out_load;
  } oms_cmd_t;

  typedef struct packed {
    logic need;
    logic meter_ok;
    logic iv_enough;
    logic scan_busy;
    logic med_found;
    logic swing_ok;
    logic sw_more;
    logic sw_pos;
    logic div_busy;
  } oms_sts_t;

endpackage

### hdl/oms_ram.sv
`timescale 1ns / 1ps
module oms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/oms_div.sv
`timescale 1ns / 1ps
module oms_div import oms_pkg::*; #(
  parameter int W = DIV_W,
  localparam int NW = $clog2(W + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder,
  output logic         busy
);

  logic [W-1:0]  quo;
  logic [W-1:0]  rem;
  logic [W-1:0]  dsr;
  logic [NW-1:0] steps;
  logic          run;
  logic [W:0]    rem_sh;
  logic [W:0]    trial;

  assign rem_sh    = {rem, quo[W-1]};
  assign trial     = rem_sh - {1'b0, dsr};
  assign quotient  = quo;
  assign remainder = rem;
  assign busy      = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
    end else if (run && steps == NW'(1)) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      rem   <= '0;
      dsr   <= divisor;
      steps <= NW'(W);
    end else if (run) begin
      rem   <= trial[W] ? rem_sh[W-1:0] : trial[W-1:0];
      quo   <= {quo[W-2:0], ~trial[W]};
      steps <= steps - 1'b1;
    end
  end

endmodule

### hdl/oms_dp.sv
`timescale 1ns / 1ps
module oms_dp import oms_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int POSITION_BITS = DEF_POSITION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  oms_cmd_t                 cmd,
  output oms_sts_t                 sts,
  input  logic [FRAME_W-1:0]       frame_count,
  input  logic                     onset_valid,
  input  logic [POSITION_BITS-1:0] onset_position,
  input  logic [SPB_W-1:0]         samples_per_beat,
  input  logic                     cfg_we,
  input  logic [INTERVAL_W-1:0]    cfg_wdata,
  output logic                     analysis_ran,
  output logic [METER_W-1:0]       beats_per_bar,
  output logic [SWING_W-1:0]       swing_amount
);

  localparam int P      = POSITION_BITS;
  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int CW     = $clog2(HISTORY_DEPTH + 1);
  localparam int DW     = P + 2;
  localparam int S3_W   = DW + 5;
  localparam int S4_W   = DW + 3;
  localparam int M9_W   = P + 4;
  localparam int SUM_W  = SPB_W + CW + 1;
  localparam int PROD_W = SUM_W - 1 + SCALE_W;
  localparam int DEN0_W = CW + HALF_W;
  localparam int DEN_W  = DEN0_W + 6;

  typedef enum logic [1:0] {SCAN_IV, SCAN_MED, SCAN_CNT} scan_mode_t;

  logic [AW-1:0]         head;
  logic [CW-1:0]         hcount;
  logic [P-1:0]          sp;
  logic [P-1:0]          last;
  logic [INTERVAL_W-1:0] interval;
  logic [SPB_W-1:0]      spb;
  logic                  ran;
  logic [METER_W-1:0]    meter;
  logic [SWING_W-1:0]    swing;
  logic [AW-1:0]         hptr;
  logic [AW-1:0]         hptr_inc;
  logic [AW-1:0]         head_inc;
  logic [CW:0]           start_w;
  logic [AW-1:0]         start_ptr;
  logic [P-1:0]          hrd;

  logic                  iv_we;
  logic [P-1:0]          iv_wdata;
  logic [AW-1:0]         iv_raddr;
  logic [P-1:0]          ivrd;

  scan_mode_t            mode;
  logic                  issue;
  logic [CW-1:0]         sidx;
  logic [CW-1:0]         slen;
  logic                  v1;
  logic                  v2;
  logic                  v3;

  logic [P-1:0]          prev;
  logic                  first;
  logic [CW-1:0]         ivn;

  logic [CW-1:0]         medk;
  logic [P-1:0]          cand;
  logic [CW-1:0]         less;
  logic [CW-1:0]         leq;
  logic [DW-1:0]         m3;
  logic [DW-1:0]         m4;
  logic [M9_W-1:0]       m9;

  logic [DW-1:0]         iv_ext;
  logic [DW-1:0]         d3;
  logic [DW-1:0]         d4;
  logic [S3_W-1:0]       s3;
  logic [S4_W-1:0]       s4;
  logic                  le;
  logic [CW-1:0]         c3;
  logic [CW-1:0]         c4;

  logic [CW-1:0]         swk;
  logic [CW-1:0]         swn;
  logic signed [SUM_W-1:0] sum;
  logic [PROD_W-1:0]     prod;
  logic [DEN0_W-1:0]     den0;
  logic [DEN_W-1:0]      den;
  logic [HALF_W-1:0]     e_half;
  logic signed [SPB_W:0] dev;
  logic [SPB_W:0]        dev_abs;
  logic                  dev_in;

  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [DIV_W-1:0]      div_divisor;
  logic [DIV_W-1:0]      quo;
  logic [DIV_W-1:0]      rem;
  logic                  div_busy;

  assign hptr_inc  = (hptr == AW'(HISTORY_DEPTH - 1)) ? '0 : hptr + 1'b1;
  assign head_inc  = (head == AW'(HISTORY_DEPTH - 1)) ? '0 : head + 1'b1;
  assign start_w   = ((CW+1)'(head) >= (CW+1)'(hcount)) ?
                     (CW+1)'(head) - (CW+1)'(hcount) :
                     (CW+1)'(head) + (CW+1)'(HISTORY_DEPTH) - (CW+1)'(hcount);
  assign start_ptr = start_w[AW-1:0];

  oms_ram #(.WIDTH(P), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .we    (cmd.accept && onset_valid),
    .waddr (head),
    .wdata (onset_position),
    .raddr (hptr),
    .rdata (hrd)
  );

  assign iv_we    = v1 && (mode == SCAN_IV) && !first && (hrd > prev);
  assign iv_wdata = hrd - prev;
  assign iv_raddr = cmd.med_rd ? medk[AW-1:0] : sidx[AW-1:0];

  oms_ram #(.WIDTH(P), .DEPTH(HISTORY_DEPTH)) u_ivals (
    .clk   (clk),
    .we    (iv_we),
    .waddr (ivn[AW-1:0]),
    .wdata (iv_wdata),
    .raddr (iv_raddr),
    .rdata (ivrd)
  );

  assign e_half  = spb[SPB_W-1:1];
  assign dev     = $signed({1'b0, rem[SPB_W-1:0]}) - $signed({2'b00, e_half});
  assign dev_abs = dev[SPB_W] ? (SPB_W+1)'(-dev) : (SPB_W+1)'(dev);
  assign dev_in  = dev_abs < (SPB_W+1)'(e_half >> 1);

  assign div_start    = cmd.sw_mod_go || cmd.sw_q_go;
  assign div_dividend = cmd.sw_q_go ? DIV_W'(prod) : DIV_W'(hrd);
  assign div_divisor  = cmd.sw_q_go ? DIV_W'(den) : DIV_W'(spb);

  oms_div #(.W(DIV_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (quo),
    .remainder (rem),
    .busy      (div_busy)
  );

  assign iv_ext = DW'(ivrd);

  always_comb begin
    sts.need      = (sp - last) >= P'(interval);
    sts.meter_ok  = hcount >= CW'(MIN_METER_ONSETS);
    sts.iv_enough = ivn >= CW'(MIN_INTERVALS);
    sts.scan_busy = issue || v1 || v2 || v3;
    sts.med_found = (less <= (ivn >> 1)) && ((ivn >> 1) < leq);
    sts.swing_ok  = (hcount >= CW'(MIN_SWING_ONSETS)) && (spb[SPB_W-1:1] != '0);
    sts.sw_more   = ((CW+1)'(swk) + 1'b1) < (CW+1)'(hcount);
    sts.sw_pos    = (swn != '0) && !sum[SUM_W-1] && (sum != '0);
    sts.div_busy  = div_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
    end else if (cfg_we) begin
      interval <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      hcount <= '0;
      sp     <= '0;
      last   <= '0;
      ran    <= 1'b0;
      meter  <= METER_FOUR;
      swing  <= '0;
    end else begin
      if (cmd.accept) begin
        sp <= sp + P'(frame_count);
        if (onset_valid) begin
          head <= head_inc;
          if (hcount != CW'(HISTORY_DEPTH)) begin
            hcount <= hcount + 1'b1;
          end
        end
      end
      if (cmd.check) begin
        ran <= sts.need;
        if (sts.need) begin
          last <= sp;
        end
      end
      if (cmd.meter_set) begin
        meter <= (c3 > c4 && c3 >= CW'(MIN_METER_HITS)) ? METER_THREE : METER_FOUR;
      end
      if (cmd.sw_zero) begin
        swing <= '0;
      end else if (cmd.sw_sat) begin
        swing <= (quo > DIV_W'(SWING_MAX)) ? SWING_MAX : quo[SWING_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      spb <= samples_per_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      ivn   <= '0;
    end else begin
      v1 <= issue;
      v2 <= v1 && (mode == SCAN_CNT);
      v3 <= v2;
      if (cmd.iv_start) begin
        issue <= hcount != '0;
        ivn   <= '0;
      end else if (cmd.med_start || cmd.cnt_start) begin
        issue <= ivn != '0;
      end else if (issue && sidx == slen - 1'b1) begin
        issue <= 1'b0;
      end
      if (iv_we) begin
        ivn <= ivn + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.iv_start) begin
      mode  <= SCAN_IV;
      slen  <= hcount;
      sidx  <= '0;
      first <= 1'b1;
      medk  <= '0;
    end else if (cmd.med_start) begin
      mode <= SCAN_MED;
      slen <= ivn;
      sidx <= '0;
    end else if (cmd.cnt_start) begin
      mode <= SCAN_CNT;
      slen <= ivn;
      sidx <= '0;
    end else if (issue) begin
      sidx <= sidx + 1'b1;
    end

    if (cmd.iv_start || cmd.sw_init) begin
      hptr <= start_ptr;
    end else if ((issue && mode == SCAN_IV) || cmd.sw_acc) begin
      hptr <= hptr_inc;
    end

    if (v1 && mode == SCAN_IV) begin
      prev  <= hrd;
      first <= 1'b0;
    end

    if (cmd.med_next) begin
      medk <= medk + 1'b1;
    end
    if (cmd.med_cap) begin
      cand <= ivrd;
    end
    if (cmd.med_start) begin
      less <= '0;
      leq  <= '0;
    end else if (v1 && mode == SCAN_MED) begin
      less <= less + CW'(ivrd < cand);
      leq  <= leq + CW'(ivrd <= cand);
    end
    if (cmd.med_take) begin
      m3 <= DW'({cand, 1'b0}) + DW'(cand);
      m4 <= DW'({cand, 2'b00});
      m9 <= M9_W'({cand, 3'b000}) + M9_W'(cand);
    end

    if (v1) begin
      d3 <= (iv_ext >= m3) ? iv_ext - m3 : m3 - iv_ext;
      d4 <= (iv_ext >= m4) ? iv_ext - m4 : m4 - iv_ext;
    end
    if (v2) begin
      s3 <= (S3_W'(d3) << 4) + (S3_W'(d3) << 2);
      s4 <= (S4_W'(d4) << 2) + S4_W'(d4);
      le <= d3 <= d4;
    end
    if (cmd.cnt_start) begin
      c3 <= '0;
      c4 <= '0;
    end else if (v3) begin
      if (s3 < S3_W'(m9) && le) begin
        c3 <= c3 + 1'b1;
      end else if (s4 < S4_W'(m3)) begin
        c4 <= c4 + 1'b1;
      end
    end

    if (cmd.sw_init) begin
      swk <= '0;
      swn <= '0;
      sum <= '0;
    end else if (cmd.sw_acc) begin
      swk <= swk + 1'b1;
      if (dev_in) begin
        swn <= swn + 1'b1;
        sum <= sum + SUM_W'(dev);
      end
    end
    if (cmd.sw_prod) begin
      prod <= sum[SUM_W-2:0] * SWING_SCALE;
      den0 <= swn * e_half;
    end
    if (cmd.sw_den) begin
      den <= (DEN_W'(den0) << 5) + DEN_W'(den0);
    end

    if (cmd.out_load) begin
      analysis_ran  <= ran;
      beats_per_bar <= meter;
      swing_amount  <= swing;
    end
  end

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("The divider was started while still busy.");

  a_iv_fill: assert property (@(posedge clk) disable iff (rst)
    ivn <= hcount)
    else $error("More intervals than stored onsets.");

  a_meter: assert property (@(posedge clk) disable iff (rst)
    meter == METER_THREE || meter == METER_FOUR)
    else $error("Meter holds a value other than three or four.");

endmodule

### hdl/oms_ctrl.sv
`timescale 1ns / 1ps
module oms_ctrl import oms_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  output logic     result_valid,
  input  logic     result_stall,
  input  oms_sts_t sts,
  output oms_cmd_t cmd
);

  typedef enum logic [22:0] {
    S_IDLE     = 23'h000001,
    S_CHECK    = 23'h000002,
    S_IV_GO    = 23'h000004,
    S_IV_RUN   = 23'h000008,
    S_MED_RD   = 23'h000010,
    S_MED_CAP  = 23'h000020,
    S_MED_GO   = 23'h000040,
    S_MED_RUN  = 23'h000080,
    S_MED_TEST = 23'h000100,
    S_CNT_GO   = 23'h000200,
    S_CNT_RUN  = 23'h000400,
    S_METER    = 23'h000800,
    S_SW_INIT  = 23'h001000,
    S_SW_RD    = 23'h002000,
    S_SW_LD    = 23'h004000,
    S_SW_DIV   = 23'h008000,
    S_SW_ACC   = 23'h010000,
    S_SW_PROD  = 23'h020000,
    S_SW_DEN   = 23'h040000,
    S_SW_QGO   = 23'h080000,
    S_SW_QRUN  = 23'h100000,
    S_SW_SAT   = 23'h200000,
    S_FINISH   = 23'h400000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (!sts.need) begin
          state_next = S_FINISH;
        end else if (sts.meter_ok) begin
          state_next = S_IV_GO;
        end else begin
          state_next = S_SW_INIT;
        end
      end
      S_IV_GO: begin
        cmd.iv_start = 1'b1;
        state_next   = S_IV_RUN;
      end
      S_IV_RUN: begin
        if (!sts.scan_busy) begin
          state_next = sts.iv_enough ? S_MED_RD : S_SW_INIT;
        end
      end
      S_MED_RD: begin
        cmd.med_rd = 1'b1;
        state_next = S_MED_CAP;
      end
      S_MED_CAP: begin
        cmd.med_cap = 1'b1;
        state_next  = S_MED_GO;
      end
      S_MED_GO: begin
        cmd.med_start = 1'b1;
        state_next    = S_MED_RUN;
      end
      S_MED_RUN: begin
        if (!sts.scan_busy) begin
          state_next = S_MED_TEST;
        end
      end
      S_MED_TEST: begin
        if (sts.med_found) begin
          cmd.med_take = 1'b1;
          state_next   = S_CNT_GO;
        end else begin
          cmd.med_next = 1'b1;
          state_next   = S_MED_RD;
        end
      end
      S_CNT_GO: begin
        cmd.cnt_start = 1'b1;
        state_next    = S_CNT_RUN;
      end
      S_CNT_RUN: begin
        if (!sts.scan_busy) begin
          state_next = S_METER;
        end
      end
      S_METER: begin
        cmd.meter_set = 1'b1;
        state_next    = S_SW_INIT;
      end
      S_SW_INIT: begin
        cmd.sw_init = 1'b1;
        state_next  = sts.swing_ok ? S_SW_RD : S_FINISH;
      end
      S_SW_RD: begin
        state_next = S_SW_LD;
      end
      S_SW_LD: begin
        cmd.sw_mod_go = 1'b1;
        state_next    = S_SW_DIV;
      end
      S_SW_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_SW_ACC;
        end
      end
      S_SW_ACC: begin
        cmd.sw_acc = 1'b1;
        state_next = sts.sw_more ? S_SW_RD : S_SW_PROD;
      end
      S_SW_PROD: begin
        if (sts.sw_pos) begin
          cmd.sw_prod = 1'b1;
          state_next  = S_SW_DEN;
        end else begin
          cmd.sw_zero = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_SW_DEN: begin
        cmd.sw_den = 1'b1;
        state_next = S_SW_QGO;
      end
      S_SW_QGO: begin
        cmd.sw_q_go = 1'b1;
        state_next  = S_SW_QRUN;
      end
      S_SW_QRUN: begin
        if (!sts.div_busy) begin
          state_next = S_SW_SAT;
        end
      end
      S_SW_SAT: begin
        cmd.sw_sat = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!result_valid || !result_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/onset_meter_and_swing_analyzer.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// item      item_valid / item_stall    frame_count, onset_valid, onset_position,
//                                      samples_per_beat
// result    result_valid / result_stall analysis_ran, beats_per_bar, swing_amount
// config    cfg_we                     cfg_wdata (analysis_interval)
//
// A beat that does not start an analysis passes from the check state straight to the finish state.
// An analysis spends most of its time in the median search over the interval memory and in the
// one-bit-a-cycle divider that reduces each onset position modulo the beat length.
// Reset is synchronous; the history memory needs no clearing.
// One beat is worked on at a time; a finished result waits in the output register and
// the next beat is accepted while it waits.
module onset_meter_and_swing_analyzer import oms_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int POSITION_BITS = DEF_POSITION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [FRAME_W-1:0]       frame_count,
  input  logic                     onset_valid,
  input  logic [POSITION_BITS-1:0] onset_position,
  input  logic [SPB_W-1:0]         samples_per_beat,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     analysis_ran,
  output logic [METER_W-1:0]       beats_per_bar,
  output logic [SWING_W-1:0]       swing_amount,
  input  logic                     cfg_we,
  input  logic [INTERVAL_W-1:0]    cfg_wdata
);

  oms_cmd_t cmd;
  oms_sts_t sts;

  oms_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  oms_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .frame_count      (frame_count),
    .onset_valid      (onset_valid),
    .onset_position   (onset_position),
    .samples_per_beat (samples_per_beat),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .analysis_ran     (analysis_ran),
    .beats_per_bar    (beats_per_bar),
    .swing_amount     (swing_amount)
  );

endmodule

### verif/oms_checker.sv
`timescale 1ns / 1ps
module oms_checker import oms_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  logic                         item_stall,
  input  logic [FRAME_W-1:0]           frame_count,
  input  logic                         onset_valid,
  input  logic [DEF_POSITION_BITS-1:0] onset_position,
  input  logic [SPB_W-1:0]             samples_per_beat,
  input  logic                         result_valid,
  input  logic                         result_stall,
  input  logic                         analysis_ran,
  input  logic [METER_W-1:0]           beats_per_bar,
  input  logic [SWING_W-1:0]           swing_amount,
  input  logic                         cfg_we,
  input  logic [INTERVAL_W-1:0]        cfg_wdata,
  output int                           errors,
  output int                           pending,
  output int                           analyses,
  output int                           triple_meters
);

  localparam int DEPTH = DEF_HISTORY_DEPTH;
  localparam logic [63:0] POS_MASK = (64'd1 << DEF_POSITION_BITS) - 64'd1;

  typedef struct {
    logic                ran;
    logic [METER_W-1:0]  meter;
    logic [SWING_W-1:0]  swing;
  } block_result_t;

  block_result_t expected_results[$];

  logic [63:0]           onsets [DEPTH];
  int                    onset_count;
  int                    onset_head;
  logic [63:0]           position;
  logic [63:0]           last_run_position;
  logic [METER_W-1:0]    meter_now;
  logic [SWING_W-1:0]    swing_now;
  logic [INTERVAL_W-1:0] interval_now;

  function automatic logic [63:0] onset_at(int k);
    return onsets[(onset_head + DEPTH - onset_count + k) % DEPTH];
  endfunction

  function automatic logic [63:0] abs_diff(logic [63:0] a, logic [63:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void update_meter();
    logic [63:0] gaps [$];
    logic [63:0] ordered [$];
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] v;
    logic [63:0] med;
    logic [63:0] d3;
    logic [63:0] d4;
    int          j;
    int          near3;
    int          near4;
    near3 = 0;
    near4 = 0;
    if (onset_count < MIN_METER_ONSETS) return;
    for (int i = 1; i < onset_count; i++) begin
      a = onset_at(i - 1);
      b = onset_at(i);
      if (b > a) gaps = {gaps, b - a};
    end
    if (gaps.size() < MIN_INTERVALS) return;
    ordered = gaps;
    for (int i = 1; i < ordered.size(); i++) begin
      v = ordered[i];
      j = i;
      while (j > 0 && ordered[j-1] > v) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = v;
    end
    med = ordered[ordered.size() / 2];
    if (med == 0) return;
    foreach (gaps[i]) begin
      d3 = abs_diff(gaps[i], med * 3);
      d4 = abs_diff(gaps[i], med * 4);
      if (d3 * 20 < med * 9 && d3 <= d4) near3++;
      else if (d4 * 5 < med * 3) near4++;
    end
    meter_now = (near3 > near4 && near3 >= MIN_METER_HITS) ? METER_THREE : METER_FOUR;
  endfunction

  function automatic void update_swing(logic [63:0] beat_len);
    logic [63:0] half;
    longint      dev;
    longint      mag;
    longint      total;
    longint      hits;
    logic [63:0] quot;
    total = 0;
    hits = 0;
    if (onset_count < MIN_SWING_ONSETS || beat_len == 0) return;
    half = beat_len / 2;
    if (half == 0) return;
    for (int i = 0; i < onset_count; i++) begin
      dev = longint'(onset_at(i) % beat_len) - longint'(half);
      mag = (dev < 0) ? -dev : dev;
      if (mag < longint'(half / 2)) begin
        total += dev;
        hits++;
      end
    end
    if (hits == 0 || total <= 0) begin
      swing_now = '0;
      return;
    end
    quot = (64'(total) * 64'(SWING_SCALE)) / (64'd33 * 64'(hits) * half);
    swing_now = (quot > 64'(SWING_MAX)) ? SWING_MAX : quot[SWING_W-1:0];
  endfunction

  function automatic block_result_t predict_block(logic [FRAME_W-1:0] frames, logic has_onset,
                                                  logic [63:0] onset_pos, logic [63:0] beat_len);
    block_result_t r;
    if (has_onset) begin
      onsets[onset_head] = onset_pos & POS_MASK;
      onset_head = (onset_head + 1) % DEPTH;
      if (onset_count < DEPTH) onset_count++;
    end
    position = (position + 64'(frames)) & POS_MASK;
    r.ran = 1'b0;
    if (((position - last_run_position) & POS_MASK) >= 64'(interval_now)) begin
      update_meter();
      update_swing(beat_len);
      last_run_position = position;
      r.ran = 1'b1;
    end
    r.meter = meter_now;
    r.swing = swing_now;
    return r;
  endfunction

  always @(posedge clk) begin
    block_result_t want;
    if (rst) begin
      expected_results.delete();
      onset_count = 0;
      onset_head = 0;
      position = '0;
      last_run_position = '0;
      meter_now = METER_FOUR;
      swing_now = '0;
      interval_now = INTERVAL_RESET;
      errors = 0;
      analyses = 0;
      triple_meters = 0;
    end else begin
      if (cfg_we) interval_now = cfg_wdata;
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: ran=%0d meter=%0d swing=%0d",
                                     analysis_ran, beats_per_bar, swing_amount);
        end else begin
          want = expected_results.pop_front();
          if (want.ran !== analysis_ran || want.meter !== beats_per_bar
              || want.swing !== swing_amount) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: expected ran=%0d meter=%0d swing=%0d, got %0d %0d %0d",
                       want.ran, want.meter, want.swing,
                       analysis_ran, beats_per_bar, swing_amount);
          end
          if (want.ran) analyses++;
          if (want.ran && want.meter == METER_THREE) triple_meters++;
        end
      end
      if (item_valid && !item_stall)
        expected_results = {expected_results,
                            predict_block(frame_count, onset_valid,
                                          64'(onset_position), 64'(samples_per_beat))};
    end
    pending = expected_results.size();
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import oms_pkg::*;

  logic                         clk;
  logic                         rst;
  logic                         item_valid;
  logic                         item_stall;
  logic [FRAME_W-1:0]           frame_count;
  logic                         onset_valid;
  logic [DEF_POSITION_BITS-1:0] onset_position;
  logic [SPB_W-1:0]             samples_per_beat;
  logic                         result_valid;
  logic                         result_stall;
  logic                         analysis_ran;
  logic [METER_W-1:0]           beats_per_bar;
  logic [SWING_W-1:0]           swing_amount;
  logic                         cfg_we;
  logic [INTERVAL_W-1:0]        cfg_wdata;
  int                           errors;
  int                           pending;
  int                           analyses;
  int                           triple_meters;
  int                           blocks_sent;
  logic                         quiet;
  int                           stall_left;
  logic [63:0]                  grid;
  logic [63:0]                  beat_len;

  onset_meter_and_swing_analyzer DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .frame_count(frame_count), .onset_valid(onset_valid),
    .onset_position(onset_position), .samples_per_beat(samples_per_beat),
    .result_valid(result_valid), .result_stall(result_stall),
    .analysis_ran(analysis_ran), .beats_per_bar(beats_per_bar),
    .swing_amount(swing_amount),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  oms_checker u_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .frame_count(frame_count), .onset_valid(onset_valid),
    .onset_position(onset_position), .samples_per_beat(samples_per_beat),
    .result_valid(result_valid), .result_stall(result_stall),
    .analysis_ran(analysis_ran), .beats_per_bar(beats_per_bar),
    .swing_amount(swing_amount),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending), .analyses(analyses), .triple_meters(triple_meters)
  );

  always #4 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      result_stall <= quiet ? 1'b0 : 1'($urandom_range(0, 1));
      stall_left <= gap_len();
    end
  end

  task automatic send_block(logic [FRAME_W-1:0] frames, logic has_onset,
                            logic [63:0] pos, logic [SPB_W-1:0] spb);
    int g;
    g = gap_len();
    if (g > 0) begin
      item_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    item_valid <= 1'b1;
    frame_count <= frames;
    onset_valid <= has_onset;
    onset_position <= pos[DEF_POSITION_BITS-1:0];
    samples_per_beat <= spb;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    blocks_sent++;
  endtask

  task automatic write_interval(logic [INTERVAL_W-1:0] value);
    item_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_block(int style);
    logic [FRAME_W-1:0] frames;
    logic [63:0]        pos;
    logic               has_onset;
    int                 r;
    int                 mult;
    r = $urandom_range(0, 99);
    frames = (r < 5) ? 16'hFFFF : (r < 10) ? 16'd0 : 16'($urandom_range(1, 3000));
    if ($urandom_range(0, 9) == 0) begin
      r = $urandom_range(0, 9);
      beat_len = (r == 0) ? 64'd0 : (r == 1) ? 64'd1 : (r == 2) ? 64'd2 :
                 (r == 3) ? 64'hFFFFFF : 64'($urandom_range(200, 5000));
    end
    has_onset = ($urandom_range(0, 99) < 88);
    r = $urandom_range(0, 99);
    if (r < 75) begin
      mult = $urandom_range(0, 9);
      mult = (mult < 6) ? 1 : (mult < 8) ? 3 : 4;
      grid = grid + 64'(mult) * ((beat_len == 0) ? 64'd700 : beat_len)
             + 64'($urandom_range(0, 8));
      pos = grid;
      if (style == 1 && beat_len > 3 && $urandom_range(0, 1))
        pos = grid + beat_len / 2 + 64'($urandom_range(0, 32'(beat_len / 4)))
              - 64'($urandom_range(0, 32'(beat_len / 6)));
    end else if (r < 90) begin
      pos = {$urandom, $urandom};
    end else begin
      pos = grid - 64'($urandom_range(1, 100000));
    end
    send_block(frames, has_onset, pos, beat_len[SPB_W-1:0]);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    frame_count = '0;
    onset_valid = 1'b0;
    onset_position = '0;
    samples_per_beat = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    quiet = 1'b1;
    blocks_sent = 0;
    grid = 64'd1000;
    beat_len = 64'd1000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_block(16'd0, 1'b0, 64'd0, 24'd0);
    send_block(16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF, 24'hFFFFFF);
    for (int i = 0; i < 14; i++) begin
      grid = grid + ((i % 4 == 3) ? 64'd3000 : 64'd1000);
      send_block(16'd4410, 1'b1, (i % 2) ? grid + 64'd600 : grid, 24'd1000);
    end
    send_block(16'd4410, 1'b0, 64'd0, 24'd1);
    send_block(16'd4410, 1'b0, 64'd0, 24'd0);
    send_block(16'd4410, 1'b1, 64'h0000_0000_0001, 24'd2);
    send_block(16'd4410, 1'b1, 64'hAAAA_AAAA_AAAA, 24'd3);
    send_block(16'd4410, 1'b1, 64'h5555_5555_5555, 24'd1000);

    quiet = 1'b0;
    write_interval(24'd1);
    for (int i = 0; i < 20; i++) random_block(i % 2);
    write_interval(24'hFFFFFF);
    for (int i = 0; i < 10; i++) random_block(0);
    for (int p = 0; p < 4; p++) begin
      write_interval(24'($urandom_range(10000, 60000)));
      quiet = (p == 2);
      grid = (p == 3) ? 64'hFFFF_FFFF_0000 : grid;
      for (int i = 0; i < 12; i++) random_block(p % 2);
    end
    item_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    $display("%0d audio blocks checked, %0d analyses among them, %0d of which found 3/4",
             blocks_sent, analyses, triple_meters);
    if (errors == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
